// ===== rtl/core/rgbc_pkg.sv =====
// Shared types, constants and register codes for the wrapped RGB 3x3 convolution.
// Depends on nothing; the MAC, sequencer, top level and testbench import it.
`timescale 1ns / 1ps

package rgbc_pkg;

  // Default frame store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Fixed field widths
  localparam int COORD_W     = 8;
  localparam int CHAN_W      = 8;
  localparam int PIXEL_W     = 3 * CHAN_W;
  localparam int FRAME_DIM_W = 9;
  localparam int COEF_W      = 16;
  localparam int COEF_ROW_W  = 3 * COEF_W;
  localparam int KERN_DIM    = 3;
  // 9 taps of 16b x 9b products fit in 28 signed bits
  localparam int ACC_W       = 28;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd4;

  localparam logic [FRAME_DIM_W-1:0] FRAME_DIM_RST = 9'd256;
  localparam logic [COEF_ROW_W-1:0]  COEFF_MID_RST = 48'h0000_0100_0000;
  localparam logic [COEF_ROW_W-1:0]  COEFF_EDGE_RST = '0;

  // Item commands
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [CHAN_W-1:0]   red_in;
    logic [CHAN_W-1:0]   green_in;
    logic [CHAN_W-1:0]   blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_col;
    logic [COORD_W-1:0]  out_row;
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;
  } out_beat_t;

  // Live configuration seen by the sequencer
  typedef struct packed {
    logic [FRAME_DIM_W-1:0]                 frame_width;
    logic [FRAME_DIM_W-1:0]                 frame_height;
    logic [KERN_DIM-1:0][COEF_ROW_W-1:0]    coeff;
  } cfg_t;

  // Sequencer to MAC control
  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

// ===== rtl/core/rgbc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; holds the frame store.
`timescale 1ns / 1ps

module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data is registered and appears in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/rgbc_mac.sv =====
// Shared multiply-accumulate: one tap per cycle, three color lanes, plus saturation.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_mac (
  input  logic                             clk,
  input  rgbc_pkg::mac_ctrl_t              ctrl,
  input  logic signed [rgbc_pkg::COEF_W-1:0] coef,
  input  logic [rgbc_pkg::PIXEL_W-1:0]     pixel,
  output logic [rgbc_pkg::PIXEL_W-1:0]     result
);
  import rgbc_pkg::*;

  localparam int PROD_W = COEF_W + CHAN_W + 1;

  logic signed [ACC_W-1:0]  acc_r   [3];
  logic signed [ACC_W-1:0]  acc_nxt [3];
  logic signed [PROD_W-1:0] prod    [3];

  // Divide by 256 toward zero, then clamp to 0..255; negatives all land on 0
  function automatic logic [CHAN_W-1:0] sat_byte(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-9:0] q;
    q = a[ACC_W-1:8];
    if (a[ACC_W-1]) begin
      return '0;
    end else if (q > (ACC_W-8)'(255)) begin
      return 8'hFF;
    end
    return q[CHAN_W-1:0];
  endfunction

  // Lane products and accumulate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = coef * $signed({1'b0, pixel[(2-i)*CHAN_W +: CHAN_W]});
      if (ctrl.clear) begin
        acc_nxt[i] = '0;
      end else if (ctrl.en) begin
        acc_nxt[i] = acc_r[i] + {{(ACC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
      end else begin
        acc_nxt[i] = acc_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      acc_r[i] <= acc_nxt[i];
    end
  end

  assign result = {sat_byte(acc_r[0]), sat_byte(acc_r[1]), sat_byte(acc_r[2])};

endmodule

// ===== rtl/core/rgbc_seq.sv =====
// Sequencer: takes items, writes pixels, walks the nine wrapped taps, drives the result.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_seq #(
  parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_stall,
  input  rgbc_pkg::in_beat_t                               in_data,
  input  rgbc_pkg::cfg_t                                   cfg,
  output logic                                             ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          ram_addr,
  output logic [rgbc_pkg::PIXEL_W-1:0]                     ram_wdata,
  output rgbc_pkg::mac_ctrl_t                              mac_ctrl,
  output logic signed [rgbc_pkg::COEF_W-1:0]               mac_coef,
  input  logic [rgbc_pkg::PIXEL_W-1:0]                     mac_result,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output rgbc_pkg::out_beat_t                              out_data
);
  import rgbc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam int XW = ($clog2(MAX_WIDTH+1) > FRAME_DIM_W) ? $clog2(MAX_WIDTH+1) : FRAME_DIM_W;
  localparam int YW = ($clog2(MAX_HEIGHT+1) > FRAME_DIM_W) ? $clog2(MAX_HEIGHT+1)
                                                            : FRAME_DIM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] TAP_LAST = 2'(KERN_DIM - 1);

  logic [2:0]        state_r, state_nxt;
  in_beat_t          item_r;
  logic [1:0]        tr_r, tr_nxt;
  logic [1:0]        tc_r, tc_nxt;
  logic [XW-1:0]     xs_r [3];
  logic [YW-1:0]     ys_r [3];
  logic              mac_en_r;
  logic signed [COEF_W-1:0] coef_r;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r;

  logic [XW-1:0]     w_eff, w_last, col_x;
  logic [YW-1:0]     h_eff, h_last, row_y;
  logic              req_ok, store_ok, issue, out_load;
  logic [ADDR_W-1:0] store_addr, tap_addr;

  // Effective frame size and neighbor coordinates of the latched item
  always_comb begin
    w_eff  = (XW'(cfg.frame_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(cfg.frame_width);
    h_eff  = (YW'(cfg.frame_height) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                       : YW'(cfg.frame_height);
    w_last = w_eff - XW'(1);
    h_last = h_eff - YW'(1);
    col_x  = XW'(item_r.col);
    row_y  = YW'(item_r.row);
    req_ok   = (col_x < w_eff) && (row_y < h_eff);
    store_ok = (col_x < XW'(MAX_WIDTH)) && (row_y < YW'(MAX_HEIGHT));
    store_addr = ADDR_W'(row_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_x);
    tap_addr   = ADDR_W'(ys_r[tr_r]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xs_r[tc_r]);
  end

  // Frame memory port
  always_comb begin
    issue     = (state_r == ST_READ);
    ram_we    = (state_r == ST_SETUP) && (item_r.cmd == CMD_STORE) && store_ok;
    ram_addr  = issue ? tap_addr : store_addr;
    ram_wdata = {item_r.red_in, item_r.green_in, item_r.blue_in};
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    tr_nxt    = tr_r;
    tc_nxt    = tc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        tr_nxt = '0;
        tc_nxt = '0;
        if (item_r.cmd == CMD_REQUEST && req_ok) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (tc_r == TAP_LAST) begin
          tc_nxt = '0;
          if (tr_r == TAP_LAST) begin
            state_nxt = ST_DRAIN;
          end else begin
            tr_nxt = tr_r + 2'd1;
          end
        end else begin
          tc_nxt = tc_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tr_r        <= '0;
      tc_r        <= '0;
      mac_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tr_r        <= tr_nxt;
      tc_r        <= tc_nxt;
      mac_en_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == ST_SETUP) begin
      xs_r[0] <= (col_x == '0) ? w_last : col_x - XW'(1);
      xs_r[1] <= col_x;
      xs_r[2] <= (col_x == w_last) ? '0 : col_x + XW'(1);
      ys_r[0] <= (row_y == '0) ? h_last : row_y - YW'(1);
      ys_r[1] <= row_y;
      ys_r[2] <= (row_y == h_last) ? '0 : row_y + YW'(1);
    end
    // coefficient travels alongside the read so it meets the data
    coef_r <= cfg.coeff[tr_r][{tc_r, 4'b0000} +: COEF_W];
    if (out_load) begin
      out_r <= '{out_col:   item_r.col,
                 out_row:   item_r.row,
                 red_out:   mac_result[2*CHAN_W +: CHAN_W],
                 green_out: mac_result[CHAN_W +: CHAN_W],
                 blue_out:  mac_result[0 +: CHAN_W]};
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign mac_ctrl.clear = (state_r == ST_SETUP);
  assign mac_ctrl.en    = mac_en_r;
  assign mac_coef       = coef_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// ===== rtl/core/wrapped_rgb_convolution_3x3.sv =====
// Top level of the wrapped RGB 3x3 convolution: config registers, frame RAM, sequencer, MAC.
// Depends on rgbc_pkg, rgbc_ram, rgbc_mac and rgbc_seq.
// A store beat passes through SETUP only; a request walks SETUP, READ for each of nine taps,
// DRAIN and DONE before out_valid, through the single-port frame RAM and one multiply-accumulate.
// The input is taken again once the result is in the output register; a stalled output holds DONE.
// Synchronous reset clears control and returns config registers to their defaults;
// the frame RAM is not cleared.
`timescale 1ns / 1ps

module wrapped_rgb_convolution_3x3 #(
  parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgbc_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgbc_pkg::out_beat_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rgbc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import rgbc_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  cfg_t                     cfg_r;
  logic                     cfg_wr;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [PIXEL_W-1:0]       ram_wdata, ram_rdata;
  mac_ctrl_t                mac_ctrl;
  logic signed [COEF_W-1:0] mac_coef;
  logic [PIXEL_W-1:0]       mac_result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_DIM_RST;
      cfg_r.frame_height <= FRAME_DIM_RST;
      cfg_r.coeff[0]     <= COEFF_EDGE_RST;
      cfg_r.coeff[1]     <= COEFF_MID_RST;
      cfg_r.coeff[2]     <= COEFF_EDGE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[FRAME_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[FRAME_DIM_W-1:0];
        REG_COEFF_TOP:    cfg_r.coeff[0]     <= pwdata[COEF_ROW_W-1:0];
        REG_COEFF_MID:    cfg_r.coeff[1]     <= pwdata[COEF_ROW_W-1:0];
        REG_COEFF_BOTTOM: cfg_r.coeff[2]     <= pwdata[COEF_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_COEFF_TOP:    prdata = CFG_DATA_W'(cfg_r.coeff[0]);
      REG_COEFF_MID:    prdata = CFG_DATA_W'(cfg_r.coeff[1]);
      REG_COEFF_BOTTOM: prdata = CFG_DATA_W'(cfg_r.coeff[2]);
      default:          prdata = '0;
    endcase
  end

  rgbc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rgbc_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .pixel  (ram_rdata),
    .result (mac_result)
  );

  rgbc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .mac_ctrl   (mac_ctrl),
    .mac_coef   (mac_coef),
    .mac_result (mac_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sim/wrapped_rgb_convolution_3x3_tb.sv =====
// Testbench for wrapped_rgb_convolution_3x3: directed and random store/request beats,
// APB register writes with readback, and a predictor of every filtered pixel.
// Depends on rgbc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module wrapped_rgb_convolution_3x3_tb;
  import rgbc_pkg::*;

  localparam int MAX_W          = MAX_WIDTH_DEF;
  localparam int MAX_H          = MAX_HEIGHT_DEF;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [COEF_ROW_W-1:0] ROW_ALL_ONE = 48'h0100_0100_0100;
  localparam logic [COEF_ROW_W-1:0] ROW_ALL_MIN = 48'h8000_8000_8000;
  localparam logic [COEF_ROW_W-1:0] ROW_ALL_MAX = 48'h7fff_7fff_7fff;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the block: frame contents, which entries hold data, and registers
  logic [PIXEL_W-1:0]    frame_copy [MAX_W*MAX_H];
  bit                    written    [MAX_W*MAX_H];
  logic [FRAME_DIM_W-1:0] width_shadow;
  logic [FRAME_DIM_W-1:0] height_shadow;
  logic [COEF_ROW_W-1:0] coeff_shadow [KERN_DIM];

  out_beat_t             pending_pixels [$];
  int                    mismatches   = 0;
  int                    beats_sent   = 0;
  int                    quiet_cycles = 0;
  int                    stall_left   = 0;
  bit                    idle_on      = 1'b1;

  wrapped_rgb_convolution_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Frame size in effect: oversized settings act as the store size
  function automatic int unsigned active_width();
    return (width_shadow > MAX_W) ? MAX_W : width_shadow;
  endfunction

  function automatic int unsigned active_height();
    return (height_shadow > MAX_H) ? MAX_H : height_shadow;
  endfunction

  // Toroidal neighbor coordinate, n > 0
  function automatic int unsigned wrap_coord(input int unsigned c, input int d, input int unsigned n);
    return (int'(c) + int'(n) + d) % int'(n);
  endfunction

  function automatic in_beat_t pixel_beat(input logic cmd, input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input logic [PIXEL_W-1:0] rgb);
    in_beat_t beat;
    beat.cmd = cmd;
    beat.col = col;
    beat.row = row;
    {beat.red_in, beat.green_in, beat.blue_in} = rgb;
    return beat;
  endfunction

  // Filtered pixel: exact Q8.8 sum over the wrapped 3x3 window, one truncation, saturate
  function automatic out_beat_t filter_pixel(input in_beat_t beat);
    out_beat_t             res;
    int unsigned           w, h;
    int unsigned           xs [3];
    int unsigned           ys [3];
    longint                sum [3];
    longint                q;
    logic [CHAN_W-1:0]     chan [3];
    logic [PIXEL_W-1:0]    px;
    logic signed [COEF_W-1:0] k;
    w = active_width();
    h = active_height();
    for (int i = 0; i < 3; i++) begin
      xs[i]  = wrap_coord(beat.col, i - 1, w);
      ys[i]  = wrap_coord(beat.row, i - 1, h);
      sum[i] = 0;
    end
    for (int t = 0; t < 9; t++) begin
      k  = coeff_shadow[t / 3][COEF_W * (t % 3) +: COEF_W];
      px = frame_copy[ys[t / 3] * MAX_W + xs[t % 3]];
      for (int ch = 0; ch < 3; ch++)
        sum[ch] += longint'(k) * longint'(px[2 * CHAN_W - CHAN_W * ch +: CHAN_W]);
    end
    for (int ch = 0; ch < 3; ch++) begin
      q = sum[ch] / 256;
      chan[ch] = (q < 0) ? 8'd0 : (q > 255) ? 8'd255 : q[CHAN_W-1:0];
    end
    res.out_col   = beat.col;
    res.out_row   = beat.row;
    res.red_out   = chan[0];
    res.green_out = chan[1];
    res.blue_out  = chan[2];
    return res;
  endfunction

  // One input beat; the shadow is updated at the edge where it is taken
  task automatic send_beat(input in_beat_t beat);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (beat.cmd == CMD_STORE) begin
      frame_copy[beat.row * MAX_W + beat.col] = {beat.red_in, beat.green_in, beat.blue_in};
      written[beat.row * MAX_W + beat.col]    = 1'b1;
    end else if (beat.col < active_width() && beat.row < active_height()) begin
      pending_pixels.push_back(filter_pixel(beat));
    end
  endtask

  // Request a pixel; any unwritten neighbor gets a random pixel stored first
  task automatic request_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned w, h, x, y;
    w = active_width();
    h = active_height();
    if (col < w && row < h) begin
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          x = wrap_coord(col, dx, w);
          y = wrap_coord(row, dy, h);
          if (!written[y * MAX_W + x])
            send_beat(pixel_beat(CMD_STORE, x[COORD_W-1:0], y[COORD_W-1:0], 24'($urandom())));
        end
    end
    send_beat(pixel_beat(CMD_REQUEST, col, row, 24'($urandom())));
  endtask

  // Setup and access phases; psel stays high so transfers can follow back to back
  task automatic apb_transfer(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic check_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] readback);
    logic [CFG_DATA_W-1:0] want;
    case (idx)
      REG_FRAME_WIDTH:  want = CFG_DATA_W'(width_shadow);
      REG_FRAME_HEIGHT: want = CFG_DATA_W'(height_shadow);
      REG_COEFF_TOP:    want = CFG_DATA_W'(coeff_shadow[0]);
      REG_COEFF_MID:    want = CFG_DATA_W'(coeff_shadow[1]);
      default:          want = CFG_DATA_W'(coeff_shadow[2]);
    endcase
    if (readback !== want)
      flag_error($sformatf("register %0d readback: expected %h, got %h", idx, want, readback));
  endtask

  // Write a register, then read it back
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    case (idx)
      REG_FRAME_WIDTH:  width_shadow    = value[FRAME_DIM_W-1:0];
      REG_FRAME_HEIGHT: height_shadow   = value[FRAME_DIM_W-1:0];
      REG_COEFF_TOP:    coeff_shadow[0] = value[COEF_ROW_W-1:0];
      REG_COEFF_MID:    coeff_shadow[1] = value[COEF_ROW_W-1:0];
      REG_COEFF_BOTTOM: coeff_shadow[2] = value[COEF_ROW_W-1:0];
      default: ;
    endcase
    apb_transfer(1'b1, idx, value, readback);
    apb_transfer(1'b0, idx, '0, readback);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_register(idx, readback);
  endtask

  // Let every result out, then give stores and silent requests time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [FRAME_DIM_W-1:0] w, input logic [FRAME_DIM_W-1:0] h,
                             input logic [COEF_ROW_W-1:0] top, input logic [COEF_ROW_W-1:0] mid,
                             input logic [COEF_ROW_W-1:0] bottom);
    wait_idle();
    set_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    set_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    set_register(REG_COEFF_TOP, CFG_DATA_W'(top));
    set_register(REG_COEFF_MID, CFG_DATA_W'(mid));
    set_register(REG_COEFF_BOTTOM, CFG_DATA_W'(bottom));
  endtask

  function automatic logic [FRAME_DIM_W-1:0] random_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return FRAME_DIM_W'($urandom_range(257, 511));
      2, 3:    return 9'd256;
      4, 5:    return FRAME_DIM_W'($urandom_range(13, 255));
      default: return FRAME_DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Full-range rows draw every bit at random; mild rows hold each coefficient in -80..80
  function automatic logic [COEF_ROW_W-1:0] random_coeff_row(input bit full);
    logic [COEF_ROW_W-1:0] row_bits;
    int                    v;
    if (full) begin
      row_bits = {16'($urandom()), $urandom()};
    end else begin
      for (int i = 0; i < KERN_DIM; i++) begin
        v = int'($urandom_range(0, 160)) - 80;
        row_bits[COEF_W * i +: COEF_W] = v[COEF_W-1:0];
      end
    end
    return row_bits;
  endfunction

  // Reset values by readback, then identity kernel across the frame corner
  task automatic test_reset_defaults();
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] readback;
    regs = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_COEFF_TOP, REG_COEFF_MID, REG_COEFF_BOTTOM};
    foreach (regs[i]) begin
      apb_transfer(1'b0, regs[i], '0, readback);
      check_register(regs[i], readback);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    send_beat(pixel_beat(CMD_STORE, 8'd255, 8'd255, 24'hffffff));
    send_beat(pixel_beat(CMD_STORE, 8'd0, 8'd0, 24'h000000));
    request_pixel(8'd0, 8'd0);
  endtask

  // 1x1 frame: all nine taps hit one pixel; requests past the edge give nothing
  task automatic test_one_pixel_frame();
    load_config(9'd1, 9'd1, ROW_ALL_ONE, ROW_ALL_ONE, ROW_ALL_ONE);
    send_beat(pixel_beat(CMD_STORE, 8'd0, 8'd0, 24'h101cff));
    request_pixel(8'd0, 8'd0);
    request_pixel(8'd1, 8'd0);
    request_pixel(8'd0, 8'd1);
  endtask

  // Zero width or zero height: requests are dropped
  task automatic test_empty_frame();
    load_config(9'd0, 9'd3, COEFF_EDGE_RST, COEFF_MID_RST, COEFF_EDGE_RST);
    request_pixel(8'd0, 8'd0);
    load_config(9'd3, 9'd0, COEFF_EDGE_RST, COEFF_MID_RST, COEFF_EDGE_RST);
    request_pixel(8'd0, 8'd0);
  endtask

  // Most negative and most positive coefficients everywhere
  task automatic test_coeff_extremes();
    load_config(9'd3, 9'd3, ROW_ALL_MIN, ROW_ALL_MIN, ROW_ALL_MIN);
    request_pixel(8'd1, 8'd1);
    load_config(9'd3, 9'd3, ROW_ALL_MAX, ROW_ALL_MAX, ROW_ALL_MAX);
    request_pixel(8'd1, 8'd1);
  endtask

  // Sizes above the store act as the store size
  task automatic test_oversized_frame();
    load_config(9'd511, 9'd300, COEFF_EDGE_RST, COEFF_MID_RST, COEFF_EDGE_RST);
    request_pixel(8'd255, 8'd255);
    request_pixel(8'd0, 8'd0);
  endtask

  // Phases of random stores and requests, each under a fresh configuration
  task automatic test_random_traffic(input int phases, input int beats_per_phase);
    logic [FRAME_DIM_W-1:0] w_cfg, h_cfg;
    bit                     full;
    int unsigned            w, h;
    int                     stop_at;
    logic [COORD_W-1:0]     col, row;
    for (int p = 0; p < phases; p++) begin
      w_cfg = (p == 0) ? 9'd256 : random_dim();
      h_cfg = (p == 0) ? 9'd256 : random_dim();
      full  = ($urandom_range(0, 3) == 0);
      load_config(w_cfg, h_cfg, random_coeff_row(full), random_coeff_row(full),
                  random_coeff_row(full));
      // last phase runs without any idling
      idle_on = (p != phases - 1) && ($urandom_range(0, 3) != 0);
      w = active_width();
      h = active_height();
      stop_at = beats_sent + beats_per_phase;
      while (beats_sent < stop_at) begin
        if (w != 0 && h != 0 && $urandom_range(0, 9) != 0) begin
          col = COORD_W'($urandom_range(0, w - 1));
          row = COORD_W'($urandom_range(0, h - 1));
        end else begin
          col = COORD_W'($urandom());
          row = COORD_W'($urandom());
        end
        if ($urandom_range(0, 99) < 45)
          send_beat(pixel_beat(CMD_STORE, col, row, 24'($urandom())));
        else
          request_pixel(col, row);
      end
    end
  endtask

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_result
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result beat at (%0d,%0d)",
                             out_data.out_col, out_data.out_row));
      end else begin
        want = pending_pixels.pop_front();
        if (want.out_col !== out_data.out_col || want.out_row !== out_data.out_row ||
            want.red_out !== out_data.red_out || want.green_out !== out_data.green_out ||
            want.blue_out !== out_data.blue_out)
          flag_error($sformatf(
            "pixel mismatch: expected (%0d,%0d) rgb %h %h %h, got (%0d,%0d) rgb %h %h %h",
            want.out_col, want.out_row, want.red_out, want.green_out, want.blue_out,
            out_data.out_col, out_data.out_row, out_data.red_out, out_data.green_out,
            out_data.blue_out));
      end
    end
  end

  // Watchdog: too long without any beat or register transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    width_shadow    = FRAME_DIM_RST;
    height_shadow   = FRAME_DIM_RST;
    coeff_shadow[0] = COEFF_EDGE_RST;
    coeff_shadow[1] = COEFF_MID_RST;
    coeff_shadow[2] = COEFF_EDGE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_one_pixel_frame();
    test_empty_frame();
    test_coeff_extremes();
    test_oversized_frame();
    test_random_traffic(10, 135);
    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
